>>> rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

    // Operation carried in the input transaction's tuser.
    typedef enum logic [2:0] {
        K_PUT     = 3'd0,
        K_CLEAR   = 3'd1,
        K_RECOLOR = 3'd2,
        K_SETCUR  = 3'd3,
        K_READ    = 3'd4,
        K_WRITE   = 3'd5
    } t_kind;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL = 2'd2;

    localparam logic [6:0] RESET_COLS = 7'd80;
    localparam logic [4:0] RESET_ROWS = 5'd25;
    localparam logic [7:0] RESET_FILL = 8'h07;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [2:0] TAB_STOP = 3'd4;

    localparam int unsigned IN_DATA_W  = 32;
    localparam int unsigned OUT_DATA_W = 40;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] char_code;
        logic [7:0] color;
        logic       use_color;
        logic [6:0] pos_x;
        logic [4:0] pos_y;
    } t_cmd;

    typedef struct packed {
        logic [6:0] columns_in_use;
        logic [4:0] rows_in_use;
        logic [7:0] fill_color;
    } t_geom;

    typedef struct packed {
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [10:0] cursor_offset;
        logic [7:0]  read_char;
        logic [7:0]  read_color;
    } t_result;

    typedef struct packed {
        logic we_char;
        logic we_attr;
        logic re;
    } t_mem_ctl;

endpackage

>>> rtl/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tcw_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/tcw_engine.sv
// Command sequencer: cursor, address generation and the sweeps over the cell store.
module tcw_engine
    import tcw_pkg::*;
#(
    parameter int unsigned MAX_COLS = 80,
    parameter int unsigned MAX_ROWS = 25
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cmd_valid,
    output logic                                    o_cmd_ready,
    input  t_cmd                                    i_cmd,
    input  t_geom                                   i_geom,
    input  logic                                    i_out_free,
    output logic                                    o_done,
    output t_result                                 o_result,
    output t_mem_ctl                                o_mem,
    output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]    o_waddr,
    output logic [7:0]                              o_wchar,
    output logic [7:0]                              o_wattr,
    output logic [$clog2(MAX_COLS*MAX_ROWS)-1:0]    o_raddr,
    input  logic [7:0]                              i_rchar,
    input  logic [7:0]                              i_rattr
);

    localparam int unsigned CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int unsigned AW = $clog2(CELL_COUNT);
    localparam int unsigned IW = AW + 2;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_PUT,
        S_SCRL_PRIME,
        S_SCRL,
        S_SWEEP,
        S_RD_WAIT,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd, n_cmd;
    logic [6:0]    r_col, n_col;
    logic [4:0]    r_line, n_line;
    logic [6:0]    r_cols, n_cols;
    logic [4:0]    r_rows, n_rows;
    logic [7:0]    r_fill, n_fill;
    logic [7:0]    r_put_ch, n_put_ch;
    logic [2:0]    r_cnt, n_cnt;
    logic [IW-1:0] r_ptr, n_ptr;
    logic [IW-1:0] r_limit, n_limit;
    logic [7:0]    r_rd_char, n_rd_char;
    logic [7:0]    r_rd_color, n_rd_color;

    logic [6:0]    w_cols_sat;
    logic [4:0]    w_rows_sat;
    logic [11:0]   w_cur_lin;
    logic [11:0]   w_pos;
    logic [11:0]   w_limit;
    logic          w_in_range;
    logic [6:0]    w_col_inc;
    logic [4:0]    w_line_inc;
    logic [IW-1:0] w_cols_iw;
    logic [IW-1:0] w_src_next;
    logic          w_copy;

    // Register values outside the legal range saturate to the screen limits.
    always_comb begin
        w_cols_sat = i_geom.columns_in_use;
        if (i_geom.columns_in_use == 7'd0) begin
            w_cols_sat = 7'd1;
        end else if (int'(i_geom.columns_in_use) > int'(MAX_COLS)) begin
            w_cols_sat = 7'(MAX_COLS);
        end
        w_rows_sat = i_geom.rows_in_use;
        if (i_geom.rows_in_use == 5'd0) begin
            w_rows_sat = 5'd1;
        end else if (int'(i_geom.rows_in_use) > int'(MAX_ROWS)) begin
            w_rows_sat = 5'(MAX_ROWS);
        end
    end

    assign w_cur_lin  = ({7'd0, r_line} * {5'd0, r_cols}) + {5'd0, r_col};
    assign w_pos      = ({7'd0, r_cmd.pos_y} * {5'd0, r_cols}) + {5'd0, r_cmd.pos_x};
    assign w_limit    = {7'd0, r_rows} * {5'd0, r_cols};
    assign w_in_range = (r_cmd.pos_x < r_cols) && (r_cmd.pos_y < r_rows);
    assign w_col_inc  = r_col + 7'd1;
    assign w_line_inc = r_line + 5'd1;
    assign w_cols_iw  = IW'(r_cols);
    assign w_src_next = r_ptr + IW'(1) + w_cols_iw;
    assign w_copy     = (r_ptr + w_cols_iw) < r_limit;

    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_col      = r_col;
        n_line     = r_line;
        n_cols     = r_cols;
        n_rows     = r_rows;
        n_fill     = r_fill;
        n_put_ch   = r_put_ch;
        n_cnt      = r_cnt;
        n_ptr      = r_ptr;
        n_limit    = r_limit;
        n_rd_char  = r_rd_char;
        n_rd_color = r_rd_color;
        o_mem      = '0;
        o_waddr    = AW'(r_ptr);
        o_wchar    = 8'd0;
        o_wattr    = r_fill;
        o_raddr    = AW'(w_src_next);
        o_done     = 1'b0;

        unique case (r_state)
            S_INIT: begin
                o_mem.we_char = 1'b1;
                o_mem.we_attr = 1'b1;
                o_wattr       = RESET_FILL;
                if (r_ptr == IW'(CELL_COUNT - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd      = i_cmd;
                    n_cols     = w_cols_sat;
                    n_rows     = w_rows_sat;
                    n_fill     = i_geom.fill_color;
                    n_rd_char  = 8'd0;
                    n_rd_color = 8'd0;
                    // A geometry change may leave the cursor off the screen.
                    if (r_col > w_cols_sat - 7'd1) begin
                        n_col = w_cols_sat - 7'd1;
                    end
                    if (r_line > w_rows_sat - 5'd1) begin
                        n_line = w_rows_sat - 5'd1;
                    end
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_limit = IW'(w_limit);
                n_ptr   = '0;
                n_state = S_DONE;
                case (r_cmd.kind)
                    K_PUT: begin
                        if (r_cmd.char_code == CH_LF) begin
                            n_col  = 7'd0;
                            n_line = w_line_inc;
                            n_cnt  = 3'd0;
                            if (w_line_inc >= r_rows) begin
                                n_state = S_SCRL_PRIME;
                            end
                        end else if (r_cmd.char_code == CH_CR) begin
                            n_col = 7'd0;
                        end else if (r_cmd.char_code == CH_TAB) begin
                            n_put_ch = CH_SPACE;
                            n_cnt    = TAB_STOP - {1'b0, r_col[1:0]};
                            n_state  = S_PUT;
                        end else begin
                            n_put_ch = r_cmd.char_code;
                            n_cnt    = 3'd1;
                            n_state  = S_PUT;
                        end
                    end
                    K_CLEAR: begin
                        n_col   = 7'd0;
                        n_line  = 5'd0;
                        n_state = S_SWEEP;
                    end
                    K_RECOLOR: begin
                        n_state = S_SWEEP;
                    end
                    K_SETCUR: begin
                        n_col  = (r_cmd.pos_x > r_cols - 7'd1) ? r_cols - 7'd1 : r_cmd.pos_x;
                        n_line = (r_cmd.pos_y > r_rows - 5'd1) ? r_rows - 5'd1 : r_cmd.pos_y;
                    end
                    K_READ: begin
                        if (w_in_range) begin
                            o_mem.re = 1'b1;
                            o_raddr  = AW'(w_pos);
                            n_state  = S_RD_WAIT;
                        end
                    end
                    K_WRITE: begin
                        if (w_in_range) begin
                            o_mem.we_char = 1'b1;
                            o_mem.we_attr = 1'b1;
                            o_waddr       = AW'(w_pos);
                            o_wchar       = r_cmd.char_code;
                            o_wattr       = r_cmd.color;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_PUT: begin
                o_mem.we_char = 1'b1;
                o_mem.we_attr = r_cmd.use_color;
                o_waddr       = AW'(w_cur_lin);
                o_wchar       = r_put_ch;
                o_wattr       = r_cmd.color;
                n_cnt         = r_cnt - 3'd1;
                n_col         = w_col_inc;
                if (r_cnt == 3'd1) begin
                    n_state = S_DONE;
                end
                if (w_col_inc >= r_cols) begin
                    n_col  = 7'd0;
                    n_line = w_line_inc;
                    if (w_line_inc >= r_rows) begin
                        n_state = S_SCRL_PRIME;
                    end
                end
            end
            S_SCRL_PRIME: begin
                // Fetch the first cell of the second row ahead of the copy.
                o_mem.re = w_cols_iw < r_limit;
                o_raddr  = AW'(w_cols_iw);
                n_ptr    = '0;
                n_state  = S_SCRL;
            end
            S_SCRL: begin
                // Each cell takes the one a row below; the bottom row is blanked.
                o_mem.we_char = 1'b1;
                o_mem.we_attr = 1'b1;
                o_wchar       = w_copy ? i_rchar : 8'd0;
                o_wattr       = w_copy ? i_rattr : r_fill;
                o_mem.re      = w_src_next < r_limit;
                if (r_ptr == r_limit - IW'(1)) begin
                    n_line  = r_line - 5'd1;
                    n_state = (r_cnt != 3'd0) ? S_PUT : S_DONE;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end
            S_SWEEP: begin
                o_mem.we_char = (r_cmd.kind == K_CLEAR);
                o_mem.we_attr = 1'b1;
                o_wattr       = (r_cmd.kind == K_CLEAR) ? r_fill : r_cmd.color;
                if (r_ptr == r_limit - IW'(1)) begin
                    n_state = S_DONE;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end
            S_RD_WAIT: begin
                n_rd_char  = i_rchar;
                n_rd_color = i_rattr;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_cmd_ready              = (r_state == S_IDLE);
    assign o_result.cursor_col      = r_col;
    assign o_result.cursor_row      = r_line;
    assign o_result.cursor_offset   = w_cur_lin[10:0];
    assign o_result.read_char       = r_rd_char;
    assign o_result.read_color      = r_rd_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr   <= '0;
            r_col   <= 7'd0;
            r_line  <= 5'd0;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_ptr   <= n_ptr;
            r_col   <= n_col;
            r_line  <= n_line;
            r_cnt   <= n_cnt;
        end
        r_cmd      <= n_cmd;
        r_cols     <= n_cols;
        r_rows     <= n_rows;
        r_fill     <= n_fill;
        r_put_ch   <= n_put_ch;
        r_limit    <= n_limit;
        r_rd_char  <= n_rd_char;
        r_rd_color <= n_rd_color;
    end

endmodule

>>> rtl/text_console_writer.sv
// Text console writer: character and attribute store with a cursor.
// Scroll, clear and recolor sweep the cells in use through the one write port of the cell
// memories. One item is in flight at a time; the next is taken while the result waits in its
// register. Reset is synchronous and active low; a clearing pass then writes every cell
// (MAX_COLS*MAX_ROWS, 2000 by default) while no input is taken. Configuration is accepted always.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int unsigned MAX_COLS = 80,
    parameter int unsigned MAX_ROWS = 25
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // char_code[7:0], color[15:8], use_color[16], pos_x[23:17], pos_y[28:24], zero pad
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    // kind[2:0]
    input  logic [2:0]            i_s_tuser,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12], read_char[30:23],
    // read_color[38:31], zero pad
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]            i_cfg_data
);

    localparam int unsigned CELL_COUNT = MAX_COLS * MAX_ROWS;
    localparam int unsigned AW = $clog2(CELL_COUNT);

    t_geom     r_geom;
    logic      r_m_valid;
    t_result   r_m_result;

    t_cmd      w_cmd;
    logic      w_out_free;
    logic      w_done;
    t_result   w_result;
    t_mem_ctl  w_mem;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_wchar;
    logic [7:0]    w_wattr;
    logic [7:0]    w_rchar;
    logic [7:0]    w_rattr;

    assign w_cmd.kind      = t_kind'(i_s_tuser);
    assign w_cmd.char_code = i_s_tdata[7:0];
    assign w_cmd.color     = i_s_tdata[15:8];
    assign w_cmd.use_color = i_s_tdata[16];
    assign w_cmd.pos_x     = i_s_tdata[23:17];
    assign w_cmd.pos_y     = i_s_tdata[28:24];

    assign w_out_free  = !r_m_valid || i_m_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_geom.columns_in_use <= RESET_COLS;
            r_geom.rows_in_use    <= RESET_ROWS;
            r_geom.fill_color     <= RESET_FILL;
            r_m_valid             <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_COLS: r_geom.columns_in_use <= i_cfg_data[6:0];
                    CFG_ROWS: r_geom.rows_in_use    <= i_cfg_data[4:0];
                    CFG_FILL: r_geom.fill_color     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_done) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (w_done) begin
            r_m_result <= w_result;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {1'b0, r_m_result.read_color, r_m_result.read_char,
                         r_m_result.cursor_offset, r_m_result.cursor_row,
                         r_m_result.cursor_col};

    tcw_engine #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_s_tvalid),
        .o_cmd_ready (o_s_tready),
        .i_cmd       (w_cmd),
        .i_geom      (r_geom),
        .i_out_free  (w_out_free),
        .o_done      (w_done),
        .o_result    (w_result),
        .o_mem       (w_mem),
        .o_waddr     (w_waddr),
        .o_wchar     (w_wchar),
        .o_wattr     (w_wattr),
        .o_raddr     (w_raddr),
        .i_rchar     (w_rchar),
        .i_rattr     (w_rattr)
    );

    tcw_ram #(
        .WIDTH (8),
        .DEPTH (CELL_COUNT)
    ) u_char_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we_char),
        .i_waddr (w_waddr),
        .i_wdata (w_wchar),
        .i_re    (w_mem.re),
        .i_raddr (w_raddr),
        .o_rdata (w_rchar)
    );

    tcw_ram #(
        .WIDTH (8),
        .DEPTH (CELL_COUNT)
    ) u_attr_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we_attr),
        .i_waddr (w_waddr),
        .i_wdata (w_wattr),
        .i_re    (w_mem.re),
        .i_raddr (w_raddr),
        .o_rdata (w_rattr)
    );

endmodule

>>> test/text_console_writer_tb.sv
// Self-checking testbench for the text console writer: directed and random command streams.
`timescale 1ns / 1ps

import tcw_pkg::*;

// Tracks the expected screen, cursor and geometry, and checks every status transaction.
class console_scoreboard #(int unsigned MAX_C = 80, int unsigned MAX_R = 25);
    logic [7:0]  glyph [MAX_C*MAX_R];
    logic [7:0]  attr [MAX_C*MAX_R];
    int unsigned cur_col;
    int unsigned cur_row;
    logic [6:0]  reg_cols;
    logic [4:0]  reg_rows;
    logic [7:0]  reg_fill;
    t_result     expected_status [$];
    int unsigned errors;

    function new();
        for (int unsigned i = 0; i < MAX_C*MAX_R; i++) begin
            glyph[i] = 8'h00;
            attr[i]  = RESET_FILL;
        end
        cur_col  = 0;
        cur_row  = 0;
        reg_cols = RESET_COLS;
        reg_rows = RESET_ROWS;
        reg_fill = RESET_FILL;
        errors   = 0;
    endfunction

    function int unsigned cols_now();
        int unsigned c;
        c = reg_cols;
        if (c < 1) c = 1;
        if (c > MAX_C) c = MAX_C;
        return c;
    endfunction

    function int unsigned rows_now();
        int unsigned r;
        r = reg_rows;
        if (r < 1) r = 1;
        if (r > MAX_R) r = MAX_R;
        return r;
    endfunction

    function int unsigned pending();
        return expected_status.size();
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] value);
        case (idx)
            CFG_COLS: reg_cols = value[6:0];
            CFG_ROWS: reg_rows = value[4:0];
            CFG_FILL: reg_fill = value;
            default: ;
        endcase
    endfunction

    // Moves every row up by one and blanks the bottom row in the fill colour.
    function void scroll_screen(int unsigned cols, int unsigned rows);
        int unsigned keep;
        keep = (rows - 1) * cols;
        for (int unsigned i = 0; i < keep; i++) begin
            glyph[i] = glyph[i + cols];
            attr[i]  = attr[i + cols];
        end
        for (int unsigned i = 0; i < cols; i++) begin
            glyph[keep + i] = 8'h00;
            attr[keep + i]  = reg_fill;
        end
        if (cur_row > 0) cur_row--;
    endfunction

    function void wrap_cursor(int unsigned cols, int unsigned rows);
        if (cur_col >= cols) begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= rows) scroll_screen(cols, rows);
    endfunction

    function void put_cell(logic [7:0] ch, logic colored, logic [7:0] colour,
                           int unsigned cols, int unsigned rows);
        int unsigned idx;
        idx = cur_row * cols + cur_col;
        if (idx < MAX_C*MAX_R) begin
            glyph[idx] = ch;
            if (colored) attr[idx] = colour;
        end
        cur_col++;
        wrap_cursor(cols, rows);
    endfunction

    // Applies one accepted command to the screen and queues the status it should return.
    function void note_command(t_cmd c);
        int unsigned cols;
        int unsigned rows;
        int unsigned spaces;
        int unsigned idx;
        int unsigned offset;
        t_result     res;
        cols = cols_now();
        rows = rows_now();
        res  = '0;
        // A geometry change may have left the cursor off the screen.
        if (cur_col > cols - 1) cur_col = cols - 1;
        if (cur_row > rows - 1) cur_row = rows - 1;
        case (c.kind)
            K_PUT: begin
                if (c.char_code == CH_LF) begin
                    cur_col = 0;
                    cur_row++;
                    wrap_cursor(cols, rows);
                end else if (c.char_code == CH_CR) begin
                    cur_col = 0;
                    wrap_cursor(cols, rows);
                end else if (c.char_code == CH_TAB) begin
                    spaces = TAB_STOP - (cur_col % TAB_STOP);
                    for (int unsigned i = 0; i < spaces; i++)
                        put_cell(CH_SPACE, c.use_color, c.color, cols, rows);
                end else begin
                    put_cell(c.char_code, c.use_color, c.color, cols, rows);
                end
            end
            K_CLEAR: begin
                for (int unsigned i = 0; i < cols * rows; i++) begin
                    glyph[i] = 8'h00;
                    attr[i]  = reg_fill;
                end
                cur_col = 0;
                cur_row = 0;
            end
            K_RECOLOR: begin
                for (int unsigned i = 0; i < cols * rows; i++) attr[i] = c.color;
            end
            K_SETCUR: begin
                cur_col = (c.pos_x > cols - 1) ? cols - 1 : c.pos_x;
                cur_row = (c.pos_y > rows - 1) ? rows - 1 : c.pos_y;
            end
            K_READ: begin
                if (c.pos_x < cols && c.pos_y < rows) begin
                    idx = c.pos_y * cols + c.pos_x;
                    res.read_char  = glyph[idx];
                    res.read_color = attr[idx];
                end
            end
            K_WRITE: begin
                if (c.pos_x < cols && c.pos_y < rows) begin
                    idx = c.pos_y * cols + c.pos_x;
                    glyph[idx] = c.char_code;
                    attr[idx]  = c.color;
                end
            end
            default: ;
        endcase
        offset = cur_row * cols + cur_col;
        res.cursor_col    = cur_col[6:0];
        res.cursor_row    = cur_row[4:0];
        res.cursor_offset = offset[10:0];
        expected_status.push_back(res);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function void check_status(logic [OUT_DATA_W-1:0] d);
        t_result want;
        if (expected_status.size() == 0) begin
            $display("%0t: status expected none, got 0x%0h", $time, d);
            errors++;
        end else begin
            want = expected_status.pop_front();
            compare_field("cursor_col", want.cursor_col, d[6:0]);
            compare_field("cursor_row", want.cursor_row, d[11:7]);
            compare_field("cursor_offset", want.cursor_offset, d[22:12]);
            compare_field("read_char", want.read_char, d[30:23]);
            compare_field("read_color", want.read_color, d[38:31]);
        end
    endfunction
endclass

module text_console_writer_tb;
    localparam int unsigned SCREEN_COLS = 80;
    localparam int unsigned SCREEN_ROWS = 25;
    localparam int unsigned PHASES      = 12;
    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    // Command kinds the block leaves undefined; they must only report the cursor.
    localparam logic [2:0] K_SPARE_A = 3'd6;
    localparam logic [2:0] K_SPARE_B = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;
    logic [2:0]            i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [7:0]            i_cfg_data;

    bit          feed_steady;
    bit          sink_steady;
    int unsigned cycle_count = 0;

    console_scoreboard #(SCREEN_COLS, SCREEN_ROWS) sb;

    text_console_writer #(
        .MAX_COLS(SCREEN_COLS),
        .MAX_ROWS(SCREEN_ROWS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Presents one command after a random gap, or none when the feed is steady, and waits until it is taken.
    task automatic issue(input logic [2:0] kind, input logic [7:0] ch, input logic [7:0] colour,
                         input logic use_colour, input logic [6:0] x, input logic [4:0] y);
        t_cmd        c;
        int unsigned gap;
        c.kind      = t_kind'(kind);
        c.char_code = ch;
        c.color     = colour;
        c.use_color = use_colour;
        c.pos_x     = x;
        c.pos_y     = y;
        gap = feed_steady ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {3'b000, y, x, use_colour, colour, ch};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_command(c);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, value);
    endtask

    task automatic wait_results();
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin : result_sink
        int unsigned gap;
        i_m_tready = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = sink_steady ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            sb.check_status(o_m_tdata);
        end
    end

    initial begin
        int unsigned cols;
        int unsigned rows;
        int unsigned items;
        int unsigned sel;
        int unsigned pick;
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic [7:0]  colour;
        logic        use_colour;
        logic [6:0]  px;
        logic [4:0]  py;
        logic [7:0]  g_cols;
        logic [7:0]  g_rows;
        logic [7:0]  g_fill;

        sb = new();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed commands on the reset geometry of 80 by 25.
        issue(K_READ, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
        issue(K_READ, 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31);
        issue(K_READ, 8'h00, 8'h00, 1'b0, 7'd79, 5'd24);
        issue(K_PUT, 8'h41, 8'hFF, 1'b0, 7'd127, 5'd31);
        issue(K_PUT, 8'hFF, 8'hFF, 1'b1, 7'd0, 5'd0);
        issue(K_PUT, 8'h00, 8'h00, 1'b1, 7'd0, 5'd0);
        issue(K_PUT, CH_TAB, 8'h5A, 1'b1, 7'd0, 5'd0);
        issue(K_PUT, CH_TAB, 8'hA5, 1'b0, 7'd0, 5'd0);
        issue(K_READ, 8'h00, 8'h00, 1'b0, 7'd5, 5'd0);
        issue(K_PUT, CH_CR, 8'h00, 1'b1, 7'd0, 5'd0);
        issue(K_PUT, CH_LF, 8'h00, 1'b1, 7'd0, 5'd0);
        issue(K_SETCUR, 8'h00, 8'h00, 1'b0, 7'd127, 5'd31);
        // The last cell wraps the cursor off the bottom row, so the screen scrolls.
        issue(K_PUT, 8'h5A, 8'h1E, 1'b1, 7'd0, 5'd0);
        issue(K_READ, 8'h00, 8'h00, 1'b0, 7'd79, 5'd23);
        issue(K_SETCUR, 8'h00, 8'h00, 1'b0, 7'd78, 5'd24);
        issue(K_PUT, CH_TAB, 8'h3C, 1'b1, 7'd0, 5'd0);
        issue(K_PUT, CH_LF, 8'h00, 1'b0, 7'd0, 5'd0);
        issue(K_WRITE, 8'hFF, 8'hFF, 1'b0, 7'd79, 5'd24);
        issue(K_WRITE, 8'h55, 8'hAA, 1'b0, 7'd80, 5'd0);
        issue(K_WRITE, 8'h55, 8'hAA, 1'b0, 7'd0, 5'd25);
        issue(K_READ, 8'h00, 8'h00, 1'b0, 7'd79, 5'd24);
        issue(K_SPARE_A, 8'hFF, 8'hFF, 1'b1, 7'd127, 5'd31);
        issue(K_SPARE_B, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
        issue(K_RECOLOR, 8'h00, 8'hA5, 1'b0, 7'd0, 5'd0);
        issue(K_READ, 8'h00, 8'h00, 1'b0, 7'd40, 5'd12);
        issue(K_CLEAR, 8'h00, 8'h00, 1'b0, 7'd0, 5'd0);
        issue(K_READ, 8'h00, 8'h00, 1'b0, 7'd79, 5'd24);

        for (int unsigned phase = 0; phase < PHASES; phase++) begin
            i_s_tvalid <= 1'b0;
            wait_results();
            // From phase 4 on, unused upper bits of the register data are randomised as well.
            case (phase)
                0: begin
                    g_cols = 8'h00;
                    g_rows = 8'h00;
                    g_fill = 8'h00;
                end
                1: begin
                    g_cols = 8'hFF;
                    g_rows = 8'hFF;
                    g_fill = 8'hFF;
                end
                2: begin
                    g_cols = 8'd1;
                    g_rows = 8'd25;
                    g_fill = 8'($urandom);
                end
                3: begin
                    g_cols = 8'd80;
                    g_rows = 8'd1;
                    g_fill = 8'($urandom);
                end
                default: begin
                    g_cols = {1'($urandom), 7'($urandom_range(1, 20))};
                    g_rows = {3'($urandom), 5'($urandom_range(1, 8))};
                    g_fill = 8'($urandom);
                end
            endcase
            write_register(CFG_COLS, g_cols);
            write_register(CFG_ROWS, g_rows);
            write_register(CFG_FILL, g_fill);
            i_cfg_valid <= 1'b0;

            feed_steady = (phase % 4 == 3) || ($urandom_range(0, 4) == 0);
            sink_steady = (phase % 4 >= 2) || ($urandom_range(0, 4) == 0);
            // The full-size screen is slow to scroll and clear, so it gets fewer commands.
            items = (phase == 1) ? 100 : 150;
            for (int unsigned n = 0; n < items; n++) begin
                cols       = sb.cols_now();
                rows       = sb.rows_now();
                ch         = 8'($urandom);
                colour     = 8'($urandom);
                use_colour = 1'($urandom);
                px         = 7'($urandom);
                py         = 5'($urandom);
                sel        = $urandom_range(0, 99);
                if (sel < 60) begin
                    kind = K_PUT;
                    pick = $urandom_range(0, 19);
                    if (pick < 10) ch = 8'($urandom_range(8'h20, 8'h7E));
                    else if (pick < 12) ch = CH_LF;
                    else if (pick < 13) ch = CH_CR;
                    else if (pick < 16) ch = CH_TAB;
                end else if (sel < 75) begin
                    kind = K_READ;
                end else if (sel < 83) begin
                    kind = K_WRITE;
                end else if (sel < 91) begin
                    kind = K_SETCUR;
                end else if (sel < 94) begin
                    kind = K_CLEAR;
                end else if (sel < 97) begin
                    kind = K_RECOLOR;
                end else begin
                    kind = $urandom_range(0, 1) ? K_SPARE_A : K_SPARE_B;
                end
                // Mostly aim at the screen or just past its edge.
                if ((kind == K_READ || kind == K_WRITE || kind == K_SETCUR)
                    && $urandom_range(0, 4) != 0) begin
                    px = 7'($urandom_range(0, cols));
                    py = 5'($urandom_range(0, rows));
                end
                issue(kind, ch, colour, use_colour, px, py);
            end
        end

        i_s_tvalid <= 1'b0;
        wait_results();
        repeat (16) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

>>> filelist.f
rtl/tcw_pkg.sv
rtl/tcw_ram.sv
rtl/tcw_engine.sv
rtl/text_console_writer.sv
test/text_console_writer_tb.sv
